// ----- rtl/sha1_byte_stream_hasher_top_defines.svh -----
`ifndef SHA1_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHA1BS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHA1BS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/sha1bs_pkg.sv -----
package sha1bs_pkg;

    typedef logic [31:0] word_t;
    typedef logic [4:0][31:0] chain_t;

    localparam word_t K_00_19 = 32'h5A827999;
    localparam word_t K_20_39 = 32'h6ED9EBA1;
    localparam word_t K_40_59 = 32'h8F1BBCDC;
    localparam word_t K_60_79 = 32'hCA62C1D6;

    // word 0 sits in the low slice
    localparam chain_t CHAIN_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [6:0] ROUND_20   = 7'd20;
    localparam logic [6:0] ROUND_40   = 7'd40;
    localparam logic [6:0] ROUND_60   = 7'd60;
    localparam logic [2:0] LAST_WORD  = 3'd4;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       byte_we;
        logic [7:0] byte_val;
        logic       word_done;
        logic       round_shift;
    } sched_ctrl_t;

    typedef struct packed {
        logic       load;
        logic       round_en;
        logic [6:0] round_idx;
        logic       accum;
        logic       reinit;
    } core_ctrl_t;

    typedef struct packed {
        logic load_digest;
        logic load_err;
    } out_ctrl_t;

    function automatic word_t rotl1(word_t x);
        return {x[30:0], x[31]};
    endfunction

    function automatic word_t rotl5(word_t x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic word_t rotl30(word_t x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage

// ----- rtl/sha1bs_sched.sv -----
module sha1bs_sched (
    input  logic                     aclk,
    input  sha1bs_pkg::sched_ctrl_t  ctrl,
    output sha1bs_pkg::word_t        w_out
);

    logic [23:0]       acc_reg;
    sha1bs_pkg::word_t win_reg [16];
    sha1bs_pkg::word_t new_word;
    sha1bs_pkg::word_t shift_word;
    logic              shift_en;

    // win_reg[i] holds W[t+i]; the shifted-in word is W[t+16]
    assign new_word   = sha1bs_pkg::rotl1(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0]);
    assign shift_en   = (ctrl.byte_we && ctrl.word_done) || ctrl.round_shift;
    assign shift_word = ctrl.byte_we ? {acc_reg, ctrl.byte_val} : new_word;
    assign w_out      = win_reg[0];

    always_ff @(posedge aclk) begin
        if (ctrl.byte_we) begin
            acc_reg <= {acc_reg[15:0], ctrl.byte_val};
        end
        if (shift_en) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= shift_word;
        end
    end

endmodule

// ----- rtl/sha1bs_core.sv -----
module sha1bs_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sha1bs_pkg::core_ctrl_t  ctrl,
    input  sha1bs_pkg::word_t       w_in,
    output sha1bs_pkg::chain_t      chain_out
);

    sha1bs_pkg::chain_t h_reg;
    sha1bs_pkg::word_t  a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1bs_pkg::word_t  f_val, k_val, a_next;

    always_comb begin
        priority if (ctrl.round_idx < sha1bs_pkg::ROUND_20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1bs_pkg::K_00_19;
        end else if (ctrl.round_idx < sha1bs_pkg::ROUND_40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1bs_pkg::K_20_39;
        end else if (ctrl.round_idx < sha1bs_pkg::ROUND_60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1bs_pkg::K_40_59;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1bs_pkg::K_60_79;
        end
    end

    assign a_next    = sha1bs_pkg::rotl5(a_reg) + f_val + e_reg + w_in + k_val;
    assign chain_out = h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg <= sha1bs_pkg::CHAIN_IV;
        end else if (ctrl.reinit) begin
            h_reg <= sha1bs_pkg::CHAIN_IV;
        end else if (ctrl.accum) begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (ctrl.round_en) begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= sha1bs_pkg::rotl30(b_reg);
            b_reg <= a_reg;
            a_reg <= a_next;
        end
    end

endmodule

// ----- rtl/sha1bs_out.sv -----
module sha1bs_out (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sha1bs_pkg::out_ctrl_t  ctrl,
    input  sha1bs_pkg::chain_t     chain_in,
    output logic                   busy,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // digest_word
    output logic                   m_tlast,   // last
    output logic [3:0]             m_tuser    // word_index[2:0], status[3]
);

    sha1bs_pkg::word_t word_reg [5];
    logic [2:0]        idx_reg;
    logic              err_reg;
    logic              valid_reg;
    logic              m_accept;
    logic              is_last;

    assign m_accept = valid_reg && m_tready;
    assign is_last  = err_reg || (idx_reg == sha1bs_pkg::LAST_WORD);

    assign busy     = valid_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = word_reg[0];
    assign m_tlast  = is_last;
    assign m_tuser  = {err_reg ? sha1bs_pkg::STATUS_OVERFLOW : sha1bs_pkg::STATUS_OK, idx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            err_reg   <= 1'b0;
        end else if (ctrl.load_digest || ctrl.load_err) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
            err_reg   <= ctrl.load_err;
        end else if (m_accept) begin
            if (is_last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_digest) begin
            for (int i = 0; i < 5; i++) begin
                word_reg[i] <= chain_in[i];
            end
        end else if (ctrl.load_err) begin
            word_reg[0] <= '0;
        end else if (m_accept && !is_last) begin
            for (int i = 0; i < 4; i++) begin
                word_reg[i] <= word_reg[i+1];
            end
        end
    end

endmodule

// ----- rtl/sha1_byte_stream_hasher_top.sv -----
// Channel | Ports                     | Item
// --------+---------------------------+-------------------------------------------
// input   | s_tvalid s_tready s_tdata | tdata data_byte[7:0], tuser cmd
//         | s_tuser                   |
// result  | m_tvalid m_tready m_tdata | tdata digest_word[31:0], tlast last,
//         | m_tlast m_tuser           | tuser word_index[2:0], status[3]
//
// A data byte is taken while idle; the 64th byte of a block starts 80 rounds through
// the single round unit, then one chaining add, with s_tready low. A finish feeds
// 64-p pad bytes (p = bytes held) at one per cycle, plus 64 more when p >= 56; on a
// length overflow it pads nothing and yields one zero item. The five result items
// leave an output register one per cycle as m_tready allows, while new bytes are
// taken; a finish waits only if the previous digest is pending.
// aresetn is synchronous, active low, and restores the initial chaining words.
module sha1_byte_stream_hasher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic        m_tlast,   // last
    output logic [3:0]  m_tuser    // word_index[2:0], status[3]
);

    sha1bs_pkg::state_t      state_reg, state_next;
    logic [5:0]              pos_reg, pos_next;
    logic [60:0]             cnt_reg, cnt_next;
    logic                    ovf_reg, ovf_next;
    logic [6:0]              round_reg, round_next;
    logic                    first_reg, first_next;
    logic                    extra_reg, extra_next;
    logic                    final_reg, final_next;
    logic                    padding_reg, padding_next;
    logic                    err_pend_reg, err_pend_next;

    sha1bs_pkg::sched_ctrl_t sched_ctrl;
    sha1bs_pkg::core_ctrl_t  core_ctrl;
    sha1bs_pkg::out_ctrl_t   out_ctrl;
    sha1bs_pkg::word_t       w_cur;
    sha1bs_pkg::chain_t      chain;
    logic                    out_busy;

    logic                    s_accept;
    logic                    absorb_cmd;
    logic                    finish_cmd;
    logic                    absorb_ok;
    logic                    byte_we;
    logic                    block_full;
    logic                    extra_eff;
    logic                    handoff;
    logic [63:0]             bit_count;
    logic [2:0]              len_sel;
    logic [7:0]              len_byte;
    logic [7:0]              pad_byte;

    assign s_tready   = (state_reg == sha1bs_pkg::ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign absorb_cmd = s_accept && (s_tuser == sha1bs_pkg::CMD_ABSORB);
    assign finish_cmd = s_accept && (s_tuser == sha1bs_pkg::CMD_FINISH);
    // once the length overflows, bytes are dropped
    assign absorb_ok  = absorb_cmd && !ovf_reg && !(&cnt_reg);

    assign bit_count  = {cnt_reg, 3'b000};
    assign len_sel    = 3'd7 - pos_reg[2:0];
    assign len_byte   = bit_count[{len_sel, 3'b000} +: 8];
    // length bytes go only into the last padded block
    assign pad_byte   = first_reg ? sha1bs_pkg::PAD_BYTE :
                        ((pos_reg >= sha1bs_pkg::LEN_POS) && !extra_reg) ? len_byte : 8'h00;
    // marker landing in the length field forces an extra all-pad block
    assign extra_eff  = first_reg ? (pos_reg >= sha1bs_pkg::LEN_POS) : extra_reg;

    assign byte_we    = absorb_ok || (state_reg == sha1bs_pkg::ST_PAD);
    assign block_full = byte_we && (pos_reg == sha1bs_pkg::LAST_POS);
    assign handoff    = (state_reg == sha1bs_pkg::ST_DONE) && !out_busy;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha1bs_pkg::ST_IDLE: begin
                if (finish_cmd) begin
                    state_next = ovf_reg ? sha1bs_pkg::ST_DONE : sha1bs_pkg::ST_PAD;
                end else if (block_full) begin
                    state_next = sha1bs_pkg::ST_ROUND;
                end
            end
            sha1bs_pkg::ST_PAD: begin
                if (block_full) begin
                    state_next = sha1bs_pkg::ST_ROUND;
                end
            end
            sha1bs_pkg::ST_ROUND: begin
                if (round_reg == sha1bs_pkg::LAST_ROUND) begin
                    state_next = sha1bs_pkg::ST_ADD;
                end
            end
            sha1bs_pkg::ST_ADD: begin
                if (final_reg) begin
                    state_next = sha1bs_pkg::ST_DONE;
                end else if (padding_reg) begin
                    state_next = sha1bs_pkg::ST_PAD;
                end else begin
                    state_next = sha1bs_pkg::ST_IDLE;
                end
            end
            sha1bs_pkg::ST_DONE: begin
                if (!out_busy) begin
                    state_next = sha1bs_pkg::ST_IDLE;
                end
            end
            default: state_next = sha1bs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        round_next    = round_reg;
        first_next    = first_reg;
        extra_next    = extra_reg;
        final_next    = final_reg;
        padding_next  = padding_reg;
        err_pend_next = err_pend_reg;

        if (absorb_cmd && !ovf_reg) begin
            cnt_next = cnt_reg + 61'd1;
            ovf_next = &cnt_reg;
        end
        if (byte_we) begin
            pos_next = pos_reg + 6'd1;
        end
        if (finish_cmd) begin
            first_next    = 1'b1;
            extra_next    = 1'b0;
            final_next    = 1'b0;
            padding_next  = 1'b1;
            err_pend_next = ovf_reg;
        end
        if (state_reg == sha1bs_pkg::ST_PAD) begin
            first_next = 1'b0;
            extra_next = block_full ? 1'b0 : extra_eff;
            if (block_full) begin
                final_next = !extra_eff;
            end
        end
        if (block_full) begin
            round_next = '0;
        end else if (state_reg == sha1bs_pkg::ST_ROUND) begin
            round_next = round_reg + 7'd1;
        end
        if (handoff) begin
            pos_next      = '0;
            cnt_next      = '0;
            ovf_next      = 1'b0;
            final_next    = 1'b0;
            padding_next  = 1'b0;
            err_pend_next = 1'b0;
        end

        sched_ctrl.byte_we     = byte_we;
        sched_ctrl.byte_val    = (state_reg == sha1bs_pkg::ST_PAD) ? pad_byte : s_tdata;
        sched_ctrl.word_done   = (pos_reg[1:0] == 2'b11);
        sched_ctrl.round_shift = (state_reg == sha1bs_pkg::ST_ROUND);

        core_ctrl.load      = block_full;
        core_ctrl.round_en  = (state_reg == sha1bs_pkg::ST_ROUND);
        core_ctrl.round_idx = round_reg;
        core_ctrl.accum     = (state_reg == sha1bs_pkg::ST_ADD);
        core_ctrl.reinit    = handoff;

        out_ctrl.load_digest = handoff && !err_pend_reg;
        out_ctrl.load_err    = handoff && err_pend_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha1bs_pkg::ST_IDLE;
            pos_reg      <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            round_reg    <= '0;
            first_reg    <= 1'b0;
            extra_reg    <= 1'b0;
            final_reg    <= 1'b0;
            padding_reg  <= 1'b0;
            err_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
            round_reg    <= round_next;
            first_reg    <= first_next;
            extra_reg    <= extra_next;
            final_reg    <= final_next;
            padding_reg  <= padding_next;
            err_pend_reg <= err_pend_next;
        end
    end

    sha1bs_sched u_sched (
        .aclk  (aclk),
        .ctrl  (sched_ctrl),
        .w_out (w_cur)
    );

    sha1bs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (core_ctrl),
        .w_in      (w_cur),
        .chain_out (chain)
    );

    sha1bs_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (out_ctrl),
        .chain_in (chain),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- rtl/sha1bs_checker.sv -----
`include "sha1_byte_stream_hasher_top_defines.svh"

module sha1bs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [3:0]  m_tuser
);

    // stalled result item must stay valid with tdata and tuser held
    `SHA1BS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")

    // an error item is a lone zero word at index 0
    `SHA1BS_ASSERT(a_err_item, m_tvalid && m_tuser[3] |-> m_tlast && (m_tuser[2:0] == 3'd0) && (m_tdata == 32'd0), "malformed overflow item")

    // a good digest ends on word 4
    `SHA1BS_ASSERT(a_last_word, m_tvalid && m_tlast && !m_tuser[3] |-> (m_tuser[2:0] == 3'd4), "digest ended on wrong word")

    // digest words follow each other without gaps in index
    `SHA1BS_ASSERT_NEXT(a_word_seq, m_tvalid && m_tready && !m_tlast, m_tvalid && !m_tuser[3] && (m_tuser[2:0] == $past(m_tuser[2:0]) + 3'd1), "digest word index skipped")

endmodule

bind sha1_byte_stream_hasher_top sha1bs_checker u_sha1bs_checker (.*);

// ----- sim/tb_sha1_byte_stream_hasher_top.sv -----
`timescale 1ns / 1ps

module tb_sha1_byte_stream_hasher_top;

    localparam int ITEM_TARGET    = 420;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int MAX_REPORTS    = 10;

    localparam logic [31:0] RC0 = 32'h5A827999;
    localparam logic [31:0] RC1 = 32'h6ED9EBA1;
    localparam logic [31:0] RC2 = 32'h8F1BBCDC;
    localparam logic [31:0] RC3 = 32'hCA62C1D6;
    localparam logic [159:0] IV_WORDS =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
    localparam logic [7:0] PAD_MARK = 8'h80;

    // well-known digests, word 0 in the top bits
    localparam logic [159:0] EMPTY_DIGEST =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] ABC_DIGEST =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
        logic        status;
    } digest_item_t;

    typedef struct {
        logic         cmd;
        logic [7:0]   data;
        bit           known;
        logic [159:0] digest;
    } stim_row_t;

    localparam int DIR_ROWS = 16;
    stim_row_t dir_tab [DIR_ROWS] = '{
        '{sha1bs_pkg::CMD_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
        '{sha1bs_pkg::CMD_ABSORB, 8'h61, 1'b0, '0},
        '{sha1bs_pkg::CMD_ABSORB, 8'h62, 1'b0, '0},
        '{sha1bs_pkg::CMD_ABSORB, 8'h63, 1'b0, '0},
        '{sha1bs_pkg::CMD_FINISH, 8'hFF, 1'b1, ABC_DIGEST},
        '{sha1bs_pkg::CMD_FINISH, 8'h5A, 1'b1, EMPTY_DIGEST},   // back-to-back finish
        '{sha1bs_pkg::CMD_ABSORB, 8'h00, 1'b0, '0},
        '{sha1bs_pkg::CMD_ABSORB, 8'hFF, 1'b0, '0},
        '{sha1bs_pkg::CMD_FINISH, 8'h00, 1'b0, '0},
        '{sha1bs_pkg::CMD_ABSORB, 8'hFF, 1'b0, '0},
        '{sha1bs_pkg::CMD_ABSORB, 8'h00, 1'b0, '0},
        '{sha1bs_pkg::CMD_ABSORB, 8'h80, 1'b0, '0},
        '{sha1bs_pkg::CMD_ABSORB, 8'h7F, 1'b0, '0},
        '{sha1bs_pkg::CMD_ABSORB, 8'h55, 1'b0, '0},
        '{sha1bs_pkg::CMD_ABSORB, 8'hAA, 1'b0, '0},
        '{sha1bs_pkg::CMD_FINISH, 8'hA5, 1'b0, '0}
    };

    localparam int EDGE_LENS = 12;
    int edge_len [EDGE_LENS] = '{0, 1, 2, 55, 56, 57, 63, 64, 65, 119, 120, 128};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    // predictor state
    logic [31:0] chain_h [5];
    logic [7:0]  blk_bytes [64];
    logic [5:0]  fill_pos;
    logic [63:0] msg_bits;
    logic        len_overflow;

    digest_item_t digest_q [$];

    int mismatches;
    int items_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_asks;
    int hold_served;
    int hold_left;
    int stall_cycles;

    sha1_byte_stream_hasher_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void hash_reinit();
        for (int i = 0; i < 5; i++)
            chain_h[i] = IV_WORDS[159 - 32 * i -: 32];
        fill_pos     = '0;
        msg_bits     = '0;
        len_overflow = 1'b0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = RC0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = RC1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RC2;
            end else begin
                f = b ^ c ^ d;
                k = RC3;
            end
            t = rol(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // Update the hash state for one accepted item and queue the digest words it yields.
    // With use_known set, the typed digest replaces the computed one.
    function automatic void hash_accept(input logic cmd, input logic [7:0] data,
                                        input bit use_known, input logic [159:0] known);
        digest_item_t it;
        logic [64:0]  sum;
        int           p;
        if (cmd == sha1bs_pkg::CMD_ABSORB) begin
            if (len_overflow)
                return;
            sum = {1'b0, msg_bits} + 65'd8;
            msg_bits = sum[63:0];
            if (msg_bits == '0) begin
                len_overflow = 1'b1;
                return;
            end
            blk_bytes[fill_pos] = data;
            fill_pos = fill_pos + 6'd1;
            if (fill_pos == '0)
                sha1_compress();
            return;
        end
        if (len_overflow) begin
            it = '{32'h0, 3'd0, 1'b1, sha1bs_pkg::STATUS_OVERFLOW};
            digest_q.push_back(it);
            hash_reinit();
            return;
        end
        p = fill_pos;
        blk_bytes[p] = PAD_MARK;
        p++;
        if (p > 56) begin
            while (p < 64) begin
                blk_bytes[p] = 8'h00;
                p++;
            end
            sha1_compress();
            p = 0;
        end
        while (p < 56) begin
            blk_bytes[p] = 8'h00;
            p++;
        end
        for (int i = 0; i < 8; i++)
            blk_bytes[56 + i] = msg_bits[63 - 8 * i -: 8];
        sha1_compress();
        for (int i = 0; i < 5; i++) begin
            it.word   = use_known ? known[159 - 32 * i -: 32] : chain_h[i];
            it.idx    = i[2:0];
            it.last   = (i == 4);
            it.status = sha1bs_pkg::STATUS_OK;
            digest_q.push_back(it);
        end
        hash_reinit();
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] data,
                             input bit use_known, input logic [159:0] known);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        hash_accept(cmd, data, use_known, known);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        for (int j = 0; j < len; j++)
            send_item(sha1bs_pkg::CMD_ABSORB, 8'($urandom_range(255)), 1'b0, '0);
        send_item(sha1bs_pkg::CMD_FINISH, 8'($urandom_range(255)), 1'b0, '0);
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", what);
    endtask

    // result side: random backpressure plus the long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_served) begin
            m_tready    <= 1'b0;
            hold_left   <= RX_HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        digest_item_t exp_it;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                note_mismatch($sformatf("unexpected item %h idx %0d last %b status %b",
                                        m_tdata, m_tuser[2:0], m_tlast, m_tuser[3]));
            end else begin
                exp_it = digest_q.pop_front();
                if (m_tdata !== exp_it.word || m_tuser[2:0] !== exp_it.idx ||
                    m_tlast !== exp_it.last || m_tuser[3] !== exp_it.status)
                    note_mismatch($sformatf(
                        "exp %h idx %0d last %b status %b, got %h idx %0d last %b status %b",
                        exp_it.word, exp_it.idx, exp_it.last, exp_it.status,
                        m_tdata, m_tuser[2:0], m_tlast, m_tuser[3]));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("sha1_byte_stream_hasher_top test failed");
            $finish;
        end
    end

    initial begin
        bit pressure_done;
        int len;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = sha1bs_pkg::CMD_ABSORB;
        mismatches   = 0;
        items_sent   = 0;
        hold_asks    = 0;
        hold_served  = 0;
        hold_left    = 0;
        stall_cycles = 0;
        tx_idle_pct  = 11;
        rx_idle_pct  = 80;
        pressure_done = 1'b0;
        hash_reinit();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_item(dir_tab[r].cmd, dir_tab[r].data, dir_tab[r].known, dir_tab[r].digest);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 2 * ITEM_TARGET / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                if (!pressure_done) begin
                    pressure_done = 1'b1;
                    // stall the result side so pending digests back up into the input
                    hold_asks++;
                    for (int m = 0; m < 4; m++)
                        send_message($urandom_range(1, 4));
                    s_tvalid <= 1'b0;
                    do @(posedge aclk); while (digest_q.size() != 0);
                end
            end else if (items_sent >= ITEM_TARGET / 3) begin
                tx_idle_pct = 80;
                rx_idle_pct = 11;
            end
            if ($urandom_range(99) < 35)
                len = edge_len[$urandom_range(EDGE_LENS - 1)];
            else
                len = $urandom_range(40);
            send_message(len);
        end

        s_tvalid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && digest_q.size() == 0)
            $display("sha1_byte_stream_hasher_top test passed");
        else
            $display("sha1_byte_stream_hasher_top test failed");
        $finish;
    end

endmodule

// ----- sha1_byte_stream_hasher_top.f -----
+incdir+rtl
rtl/sha1bs_pkg.sv
rtl/sha1bs_sched.sv
rtl/sha1bs_core.sv
rtl/sha1bs_out.sv
rtl/sha1_byte_stream_hasher_top.sv
rtl/sha1bs_checker.sv
sim/tb_sha1_byte_stream_hasher_top.sv
